// ===== rtl/core/htfl_pkg.sv =====
`default_nettype none
// ============================================================================
// htfl_pkg - shared types and constants of the handle table free list unit
// Operation and status codes, fixed field widths, register map.
// ============================================================================
package htfl_pkg;

    // fixed field widths
    localparam int CAT_W    = 3;
    localparam int DESC_W   = 11;
    localparam int CFG_W    = 9;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register map (word index = paddr[2])
    localparam logic REG_ENTRIES_PER_CAT = 1'b0;
    localparam logic [CFG_W-1:0] EPC_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_OPEN,
        OP_CLOSE,
        OP_GET,
        OP_SET
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_INVALID
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/core/handle_table_free_list_unit.sv =====
`default_nettype none
// ============================================================================
// handle_table_free_list_unit - categorized descriptor table, LIFO free lists
// Open / close / get / set on a descriptor table split into categories.
// ============================================================================
//
// Usage: present a command word on i_operation/i_category/i_descriptor/i_value
// with start high; it is taken on the edge where busy is low. Exactly one
// result word follows, valid on the o_* result ports for a single cycle while
// o_done is high; it is registered at the end of the write-back cycle. Each
// command has two phases: the accept cycle sends the entry address to the
// value and link memories, and the write-back cycle (PH_WB) consumes the
// registered read data (link of the free-list head, or stored value) and
// writes back. busy is high for the write-back cycle, so a new command can be
// taken in the cycle that shows the previous result, but never while one is
// in write-back, as the entry memory reads are registered. The per-category
// counters and free-list heads are flops and clear at reset at once; no entry
// data is used before being written, so there is no clearing pass and the
// unit takes commands from the first cycle after reset.
// Config (APB, pready tied high): register 0 at byte 0 is
// entries_per_category (9 bits, reset 256), clamped to 1..ENTRIES on use.
// Write it only while the unit is idle.
//
module handle_table_free_list_unit #(
    parameter int CATEGORIES  = 8,
    parameter int ENTRIES     = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command side
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [htfl_pkg::CAT_W-1:0]  i_category,
    input  wire logic [htfl_pkg::DESC_W-1:0] i_descriptor,
    input  wire logic [VALUE_WIDTH-1:0]      i_value,
    // result side
    output      logic                        o_done,
    output      logic [htfl_pkg::DESC_W-1:0] o_descriptor_out,
    output      logic [VALUE_WIDTH-1:0]      o_value_out,
    output      logic [1:0]                  o_status,
    // config port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [htfl_pkg::APB_AW-1:0] paddr,
    input  wire logic [htfl_pkg::APB_DW-1:0] pwdata,
    output      logic [htfl_pkg::APB_DW-1:0] prdata,
    output      logic                        pready
);
    import htfl_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);          // slot index
    localparam int CNT_W  = SLOT_W + 1;               // 0..ENTRIES
    localparam int CI_W   = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam int DEPTH  = CATEGORIES * ENTRIES;
    localparam int AW     = $clog2(DEPTH);
    localparam int BASE_W = (CAT_W + CNT_W > DESC_W) ? CAT_W + CNT_W : DESC_W;
    localparam logic [CNT_W-1:0] NO_SLOT = CNT_W'(ENTRIES);

    typedef enum logic {
        PH_IDLE,
        PH_WB
    } t_phase;

    // ---------------------------------------------------------------- state
    t_phase               r_phase;
    logic                 r_done;
    logic [DESC_W-1:0]    r_desc_o;
    logic [VALUE_WIDTH-1:0] r_value_o;
    t_status              r_status_o;
    logic [CFG_W-1:0]     r_epc;
    logic [CNT_W-1:0]     r_head [CATEGORIES];  // free-list top, NO_SLOT = empty
    logic [CNT_W-1:0]     r_used [CATEGORIES];  // slots handed out so far

    // command held for the write-back cycle
    t_op                  r_op;
    logic [CI_W-1:0]      r_cat;
    logic [SLOT_W-1:0]    r_slot;
    logic [AW-1:0]        r_addr;
    logic                 r_ok;
    logic                 r_full;
    logic                 r_from_list;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [DESC_W-1:0]    r_base;

    // ---------------------------------------------------------------- config
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRIES_PER_CAT) ? APB_DW'(r_epc) : '0;

    // effective category size, clamped to 1..ENTRIES
    logic [CNT_W-1:0] size;
    always_comb begin
        if (r_epc == '0) begin
            size = CNT_W'(1);
        end else if (32'(r_epc) > 32'(ENTRIES)) begin
            size = NO_SLOT;
        end else begin
            size = CNT_W'(r_epc);
        end
    end

    // ---------------------------------------------------------------- decode
    logic              accept;
    t_op               op_in;
    logic              cat_ok;
    logic [CI_W-1:0]   cat_idx;
    logic [CNT_W-1:0]  head_c;
    logic [CNT_W-1:0]  used_c;
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] desc_x;
    logic [BASE_W-1:0] k;
    logic              k_ok;
    logic              from_list;
    logic              fresh_ok;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic [AW-1:0]     raddr;

    assign accept = start & (r_phase == PH_IDLE);
    assign op_in  = t_op'(i_operation);
    assign cat_ok = 32'(i_category) < 32'(CATEGORIES);
    assign cat_idx = cat_ok ? CI_W'(i_category) : '0;
    assign head_c = r_head[cat_idx];
    assign used_c = r_used[cat_idx];

    // descriptor range of the category: base .. base + size - 1
    assign base   = BASE_W'(i_category) * BASE_W'(size);
    assign desc_x = BASE_W'(i_descriptor);
    assign k      = desc_x - base;
    assign k_ok   = (desc_x >= base) && (k < BASE_W'(size)) && (k < BASE_W'(used_c));

    assign from_list = (head_c != NO_SLOT);
    assign fresh_ok  = (used_c < size);

    always_comb begin
        if (op_in == OP_OPEN) begin
            slot = from_list ? head_c[SLOT_W-1:0] : used_c[SLOT_W-1:0];
            ok   = cat_ok & (from_list | fresh_ok);
        end else begin
            slot = k[SLOT_W-1:0];
            ok   = cat_ok & k_ok;
        end
    end

    assign raddr = AW'(cat_idx) * AW'(ENTRIES) + AW'(slot);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= op_in;
            r_cat       <= cat_idx;
            r_slot      <= slot;
            r_addr      <= raddr;
            r_ok        <= ok;
            r_full      <= cat_ok & (op_in == OP_OPEN) & ~ok;
            r_from_list <= from_list;
            r_value     <= i_value;
            r_base      <= base[DESC_W-1:0];
        end
    end

    // ---------------------------------------------------------------- memories
    logic                   val_we;
    logic [VALUE_WIDTH-1:0] val_wdata;
    logic [VALUE_WIDTH-1:0] val_rd;
    logic                   lnk_we;
    logic [CNT_W-1:0]       lnk_wdata;
    logic [CNT_W-1:0]       lnk_rd;

    htfl_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_addr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (val_rd)
    );

    htfl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (r_addr),
        .i_wdata (lnk_wdata),
        .i_raddr (raddr),
        .o_rdata (lnk_rd)
    );

    // ---------------------------------------------------------------- write-back
    logic [CNT_W-1:0]       lnk_next;
    logic                   head_we;
    logic [CNT_W-1:0]       head_wdata;
    logic                   used_inc;
    logic [DESC_W-1:0]      n_desc_o;
    logic [VALUE_WIDTH-1:0] n_value_o;
    t_status                n_status_o;

    // a popped link beyond the end marker reads as empty
    assign lnk_next = (lnk_rd > NO_SLOT) ? NO_SLOT : lnk_rd;

    always_comb begin
        val_we     = 1'b0;
        val_wdata  = r_value;
        lnk_we     = 1'b0;
        lnk_wdata  = NO_SLOT;
        head_we    = 1'b0;
        head_wdata = lnk_next;
        used_inc   = 1'b0;
        n_desc_o   = '0;
        n_value_o  = '0;
        n_status_o = ST_INVALID;
        if (r_phase == PH_WB) begin
            unique case (r_op)
                OP_OPEN: begin
                    if (r_ok) begin
                        val_we     = 1'b1;
                        lnk_we     = 1'b1;
                        head_we    = r_from_list;
                        used_inc   = ~r_from_list;
                        n_desc_o   = r_base + DESC_W'(r_slot);
                        n_status_o = ST_OK;
                    end else if (r_full) begin
                        n_status_o = ST_FULL;
                    end
                end
                OP_CLOSE: begin
                    // closing an entry that already reads zero is ignored
                    if (r_ok && (val_rd != '0)) begin
                        val_we     = 1'b1;
                        val_wdata  = '0;
                        lnk_we     = 1'b1;
                        lnk_wdata  = r_head[r_cat];
                        head_we    = 1'b1;
                        head_wdata = CNT_W'(r_slot);
                        n_status_o = ST_OK;
                    end
                end
                OP_GET: begin
                    if (r_ok) begin
                        n_value_o  = val_rd;
                        n_status_o = ST_OK;
                    end
                end
                OP_SET: begin
                    if (r_ok) begin
                        val_we     = 1'b1;
                        n_status_o = ST_OK;
                    end
                end
                default: begin
                    n_status_o = ST_INVALID;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_done     <= 1'b0;
            r_desc_o   <= '0;
            r_value_o  <= '0;
            r_status_o <= ST_OK;
            r_epc      <= EPC_RESET;
            for (int i = 0; i < CATEGORIES; i++) begin
                r_head[i] <= NO_SLOT;
                r_used[i] <= '0;
            end
        end else begin
            r_done <= (r_phase == PH_WB);
            unique case (r_phase)
                PH_IDLE: begin
                    if (accept) begin
                        r_phase <= PH_WB;
                    end
                end
                PH_WB: begin
                    r_phase    <= PH_IDLE;
                    r_desc_o   <= n_desc_o;
                    r_value_o  <= n_value_o;
                    r_status_o <= n_status_o;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
            if (cfg_wr && (paddr[2] == REG_ENTRIES_PER_CAT)) begin
                r_epc <= pwdata[CFG_W-1:0];
            end
            if (head_we) begin
                r_head[r_cat] <= head_wdata;
            end
            if (used_inc) begin
                r_used[r_cat] <= r_used[r_cat] + CNT_W'(1);
            end
        end
    end

    assign busy             = (r_phase == PH_WB);
    assign o_done           = r_done;
    assign o_descriptor_out = r_desc_o;
    assign o_value_out      = r_value_o;
    assign o_status         = r_status_o;

endmodule
`default_nettype wire

// ===== rtl/core/htfl_ram.sv =====
`default_nettype none
// ============================================================================
// htfl_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ============================================================================
module htfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/htfl_checker.sv =====
`default_nettype none
// ============================================================================
// htfl_checker - port-level checks for handle_table_free_list_unit
// Command/result timing and result word consistency.
// ============================================================================
module htfl_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_done,
    input wire logic [htfl_pkg::DESC_W-1:0] o_descriptor_out,
    input wire logic [VALUE_WIDTH-1:0]      o_value_out,
    input wire logic [1:0]                  o_status
);
    import htfl_pkg::*;

    // unit is busy for the cycle after every accepted command
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // result word registered from the write-back cycle of every accept
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result missing two cycles after accept");

    // no result without a command in flight
    a_done_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without command");

    // failed commands carry a zero payload and a defined status
    a_fail_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |->
            ((o_descriptor_out == '0) && (o_value_out == '0) &&
             ((o_status == ST_FULL) || (o_status == ST_INVALID))))
        else $error("bad failure result");

endmodule

bind handle_table_free_list_unit htfl_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_htfl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_descriptor_out (o_descriptor_out),
    .o_value_out      (o_value_out),
    .o_status         (o_status)
);
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
// ============================================================================
// tb - self-checking bench for handle_table_free_list_unit
// Drives open/close/get/set command words and checks each result word against
// an in-bench model of the category table and its LIFO free lists. Starts
// with a short table of directed commands, then runs random phases at several
// category sizes, written over the APB port between phases.
// ============================================================================
module tb;
    import htfl_pkg::*;

    localparam int N_CAT   = 8;
    localparam int N_ENT   = 256;
    localparam int VAL_W   = 32;
    localparam int LIMIT   = 40000;  // cycles
    localparam int N_PHASE = 8;
    localparam int PER_PHASE = 50;

    // one result word as the unit reports it
    typedef struct packed {
        logic [DESC_W-1:0] desc;
        logic [VAL_W-1:0]  value;
        t_status           status;
    } t_reply;

    // one row of the directed table: a command word or a size write
    typedef struct {
        bit             cfg;
        bit             typed;     // want holds a hand-written answer
        t_op            op;
        int             cat;
        int             desc;
        logic [VAL_W-1:0] val;
        t_reply         want;
    } t_step;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_operation;
    logic [CAT_W-1:0]    i_category;
    logic [DESC_W-1:0]   i_descriptor;
    logic [VAL_W-1:0]    i_value;
    logic                o_done;
    logic [DESC_W-1:0]   o_descriptor_out;
    logic [VAL_W-1:0]    o_value_out;
    logic [1:0]          o_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    handle_table_free_list_unit #(
        .CATEGORIES (N_CAT),
        .ENTRIES    (N_ENT),
        .VALUE_WIDTH(VAL_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_category      (i_category),
        .i_descriptor    (i_descriptor),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_descriptor_out(o_descriptor_out),
        .o_value_out     (o_value_out),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Table model: stored values and free links per entry, slot counter and
    // free-list head per category, plus the size register as last written.
    // ------------------------------------------------------------------------
    logic [VAL_W-1:0] stored_val [N_CAT*N_ENT];
    int               next_free  [N_CAT*N_ENT];
    int               used_slots [N_CAT];
    int               free_top   [N_CAT];    // N_ENT marks an empty list
    logic [CFG_W-1:0] cat_size_reg;

    t_reply  expected_words [$];   // results still owed by the unit
    t_step   directed_plan  [$];
    t_reply  head_word;

    int n_cmds, n_opened, n_full, n_invalid, n_checked, n_errors;
    int cycle_count;

    // size register as the unit uses it: clamped to 1..N_ENT
    function automatic int active_size();
        int s;
        s = cat_size_reg;
        if (s < 1) s = 1;
        if (s > N_ENT) s = N_ENT;
        return s;
    endfunction

    // Applies one command word to the model and returns the result word.
    function automatic t_reply model_table_op(t_op op, int c, int d, logic [VAL_W-1:0] val);
        t_reply r;
        int s, slot, at, base;
        bit got;
        r = '0;
        r.status = ST_OK;
        s = active_size();
        base = c * s;
        slot = 0;
        got = 1'b0;
        if (op == OP_OPEN) begin
            // most recently closed entry first, else the next unused slot
            if (free_top[c] < N_ENT) begin
                slot = free_top[c];
                free_top[c] = next_free[c*N_ENT + slot];
                got = 1'b1;
            end else if (used_slots[c] < s) begin
                slot = used_slots[c];
                used_slots[c] = used_slots[c] + 1;
                got = 1'b1;
            end
            if (got) begin
                at = c*N_ENT + slot;
                stored_val[at] = val;
                next_free[at] = N_ENT;
                // slot may lie past a size that shrank after use
                r.desc = DESC_W'(base + slot);
            end else begin
                r.status = ST_FULL;
            end
        end else if (d < base || d - base >= s || d - base >= used_slots[c]) begin
            r.status = ST_INVALID;
        end else begin
            slot = d - base;
            at = c*N_ENT + slot;
            case (op)
                OP_CLOSE: begin
                    // a zero value reads as closed: nothing to push
                    if (stored_val[at] == '0) begin
                        r.status = ST_INVALID;
                    end else begin
                        stored_val[at] = '0;
                        next_free[at] = free_top[c];
                        free_top[c] = slot;
                    end
                end
                OP_GET: begin
                    r.value = stored_val[at];
                end
                default: begin
                    stored_val[at] = val;
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_step cmd_row(bit typed, t_op op, int cat, int desc,
                                      logic [VAL_W-1:0] val, int wdesc = 0,
                                      logic [VAL_W-1:0] wval = '0,
                                      t_status wst = ST_OK);
        t_step r;
        r.cfg = 1'b0;
        r.typed = typed;
        r.op = op;
        r.cat = cat;
        r.desc = desc;
        r.val = val;
        r.want.desc = DESC_W'(wdesc);
        r.want.value = wval;
        r.want.status = wst;
        return r;
    endfunction

    function automatic t_step cfg_row(int size);
        t_step r;
        r = cmd_row(1'b0, OP_OPEN, 0, 0, VAL_W'(size));
        r.cfg = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Every task is entered just after a rising edge and leaves
    // just after one; start is touched at most once per edge.
    // ------------------------------------------------------------------------

    // Presents a command word and holds it until the unit takes it; the
    // model is stepped at the accepting edge.
    task automatic issue_cmd(t_op op, int cat, int desc, logic [VAL_W-1:0] val,
                             bit typed, t_reply want);
        t_reply pred;
        start        <= 1'b1;
        i_operation  <= op;
        i_category   <= CAT_W'(cat);
        i_descriptor <= DESC_W'(desc);
        i_value      <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = model_table_op(op, cat, desc, val);
        expected_words.push_back(typed ? want : pred);
        n_cmds++;
        if (op == OP_OPEN && pred.status == ST_OK) n_opened++;
        if (pred.status == ST_FULL) n_full++;
        if (pred.status == ST_INVALID) n_invalid++;
    endtask

    // random idle burst, taken with the given odds in percent
    task automatic sender_gap(int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every owed result word
    task automatic drain_results();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // APB write of entries_per_category; upper data bits carry junk
    task automatic write_cat_size(logic [CFG_W-1:0] size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENTRIES_PER_CAT, 2'b00};
        pwdata  <= {(APB_DW-CFG_W)'($urandom), size};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cat_size_reg = size;
    endtask

    // Random command: mostly descriptors the category really handed out, so
    // close/get/set reach live and closed entries; the rest is noise.
    task automatic issue_random_cmd();
        t_op op;
        int pick, cat, desc, s;
        logic [VAL_W-1:0] val;
        t_reply none;
        none = '0;
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_OPEN;
        else if (pick < 62) op = OP_CLOSE;
        else if (pick < 80) op = OP_GET;
        else op = OP_SET;
        // lean on the low categories so they fill up and recycle
        cat = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, N_CAT-1);
        s = active_size();
        if (used_slots[cat] > 0 && $urandom_range(0, 99) < 85)
            desc = (cat*s + $urandom_range(0, used_slots[cat]-1)) % (1 << DESC_W);
        else
            desc = $urandom_range(0, (1 << DESC_W) - 1);
        pick = $urandom_range(0, 19);
        if (pick == 0) val = '0;
        else if (pick == 1) val = '1;
        else val = $urandom;
        issue_cmd(op, cat, desc, val, 1'b0, none);
    endtask

    // ------------------------------------------------------------------------
    // Result side: the receiver cannot stall, so every o_done cycle is taken
    // and compared against the oldest owed word.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing owed: desc %0d value %h status %0d",
                       o_descriptor_out, o_value_out, o_status);
                n_errors++;
            end else begin
                head_word = expected_words.pop_front();
                n_checked++;
                if (o_descriptor_out !== head_word.desc) begin
                    $error("descriptor_out: expected %0d, got %0d",
                           head_word.desc, o_descriptor_out);
                    n_errors++;
                end
                if (o_value_out !== head_word.value) begin
                    $error("value_out: expected %h, got %h", head_word.value, o_value_out);
                    n_errors++;
                end
                if (o_status !== head_word.status) begin
                    $error("status: expected %0d, got %0d", head_word.status, o_status);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles, %0d result words still owed",
                     cycle_count, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    int phase_sizes [N_PHASE] = '{3, 1, 0, 511, 2, 256, 5, 40};

    initial begin
        t_step row;
        int gap_pct;

        n_cmds = 0; n_opened = 0; n_full = 0; n_invalid = 0;
        n_checked = 0; n_errors = 0; cycle_count = 0;
        cat_size_reg = EPC_RESET;
        for (int i = 0; i < N_CAT*N_ENT; i++) begin
            stored_val[i] = '0;
            next_free[i] = N_ENT;
        end
        for (int c = 0; c < N_CAT; c++) begin
            used_slots[c] = 0;
            free_top[c] = N_ENT;
        end

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_operation  <= '0;
        i_category   <= '0;
        i_descriptor <= '0;
        i_value      <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;

        // Directed rows at the reset size of 256, then size 1, then 511.
        // Nothing handed out yet: every descriptor is invalid.
        directed_plan.push_back(cmd_row(1, OP_GET,   0, 0,    '0, 0, '0, ST_INVALID));
        directed_plan.push_back(cmd_row(1, OP_CLOSE, 7, 2047, '0, 0, '0, ST_INVALID));
        // first slots of the lowest and highest categories, extreme values
        directed_plan.push_back(cmd_row(1, OP_OPEN,  0, 0,    '1, 0, '0, ST_OK));
        directed_plan.push_back(cmd_row(1, OP_OPEN,  7, 2047, 32'd1, 1792, '0, ST_OK));
        directed_plan.push_back(cmd_row(1, OP_GET,   7, 1792, '0, 0, 32'd1, ST_OK));
        directed_plan.push_back(cmd_row(1, OP_GET,   0, 0,    '0, 0, '1, ST_OK));
        // set to zero makes the entry read as closed, so close ignores it
        directed_plan.push_back(cmd_row(1, OP_SET,   0, 0,    '0, 0, '0, ST_OK));
        directed_plan.push_back(cmd_row(1, OP_CLOSE, 0, 0,    '0, 0, '0, ST_INVALID));
        directed_plan.push_back(cmd_row(1, OP_SET,   0, 0,    32'h5a5a, 0, '0, ST_OK));
        directed_plan.push_back(cmd_row(1, OP_CLOSE, 0, 0,    '0, 0, '0, ST_OK));
        // double close is ignored; a closed valid entry still reads as zero
        directed_plan.push_back(cmd_row(1, OP_CLOSE, 0, 0,    '0, 0, '0, ST_INVALID));
        directed_plan.push_back(cmd_row(1, OP_GET,   0, 0,    '0, 0, '0, ST_OK));
        // set on a closed entry, then close again: pushed onto the list twice
        directed_plan.push_back(cmd_row(1, OP_SET,   0, 0,    32'h1234, 0, '0, ST_OK));
        directed_plan.push_back(cmd_row(1, OP_CLOSE, 0, 0,    '0, 0, '0, ST_OK));
        directed_plan.push_back(cmd_row(0, OP_OPEN,  0, 0,    32'd7));
        directed_plan.push_back(cmd_row(0, OP_OPEN,  0, 0,    32'd8));
        directed_plan.push_back(cmd_row(0, OP_OPEN,  0, 0,    32'd9));
        // below the category base, and a slot never handed out
        directed_plan.push_back(cmd_row(1, OP_GET,   1, 0,    '0, 0, '0, ST_INVALID));
        directed_plan.push_back(cmd_row(1, OP_SET,   3, 768,  32'd1, 0, '0, ST_INVALID));
        // size 1: a category fills on its first open; old slots go out of range
        directed_plan.push_back(cfg_row(1));
        directed_plan.push_back(cmd_row(1, OP_OPEN,  5, 0,    32'd3, 5, '0, ST_OK));
        directed_plan.push_back(cmd_row(1, OP_OPEN,  5, 0,    32'd4, 0, '0, ST_FULL));
        directed_plan.push_back(cmd_row(0, OP_GET,   7, 7,    '0));
        directed_plan.push_back(cmd_row(0, OP_OPEN,  0, 0,    32'd5));
        directed_plan.push_back(cfg_row(511));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            row = directed_plan[k];
            if (row.cfg) begin
                drain_results();
                write_cat_size(row.val[CFG_W-1:0]);
            end else begin
                issue_cmd(row.op, row.cat, row.desc, row.val, row.typed, row.want);
                sender_gap(30);
            end
        end

        // Random phases, one size each. Phases 2 and the last run back to
        // back with no gaps; phase 4 stops once mid-way to let the unit run dry.
        for (int p = 0; p < N_PHASE; p++) begin
            drain_results();
            write_cat_size(CFG_W'(phase_sizes[p]));
            gap_pct = (p == 2 || p == N_PHASE-1) ? 0 : 30;
            for (int i = 0; i < PER_PHASE; i++) begin
                issue_random_cmd();
                if (p == 4 && i == PER_PHASE/2)
                    drain_results();
                else
                    sender_gap(gap_pct);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            n_errors++;
        end

        $display("%0d command words over %0d category sizes: %0d opens granted, %0d full",
                 n_cmds, N_PHASE + 3, n_opened, n_full);
        $display("%0d rejected as invalid, %0d result words compared, %0d mismatches",
                 n_invalid, n_checked, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
